>>> hdl/file_send_protocol_fsm_defines.svh
// Assertion macros for the file send controller.
// FSP_ASSERT checks on clk with reset masked; FSP_ASSERT_ALWAYS also checks in reset.
`ifndef FILE_SEND_PROTOCOL_FSM_DEFINES_SVH
`define FILE_SEND_PROTOCOL_FSM_DEFINES_SVH

`ifndef SYNTHESIS
`define FSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FSP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define FSP_ASSERT(lbl, prop)
`define FSP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> hdl/fsp_pkg.sv
`default_nettype none

package fsp_pkg;

    localparam int SEQ_W = 6;
    localparam int TRY_W = 8;
    localparam logic [TRY_W-1:0] TRY_TOP         = 8'd255;
    localparam logic [TRY_W-1:0] MAX_TRIES_RESET = 8'd10;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;

    localparam logic [1:0] REPLY_ACK = 2'd0;
    localparam logic [1:0] REPLY_NAK = 2'd1;

    localparam logic [2:0] SEND_NONE = 3'd5;

    localparam logic [1:0] STATUS_RUNNING  = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [1:0] STATUS_ABORTED  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_INIT  = 3'd1,
        PH_FILE  = 3'd2,
        PH_DATA  = 3'd3,
        PH_EOF   = 3'd4,
        PH_BREAK = 3'd5,
        PH_DONE  = 3'd6,
        PH_ABORT = 3'd7
    } phase_t;

    typedef struct packed {
        logic             more_files;
        logic             data_eof;
        logic             file_ok;
        logic [SEQ_W-1:0] reply_seq;
        logic [1:0]       reply_type;
        logic [1:0]       cmd;
    } item_t;

    typedef struct packed {
        phase_t           phase;
        logic [SEQ_W-1:0] seq;
        logic [TRY_W-1:0] tries;
    } ctl_state_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [SEQ_W-1:0] send_seq;
        logic [2:0]       send_type;
    } result_t;

    function automatic logic is_sending(input phase_t ph);
        is_sending = (ph == PH_INIT) || (ph == PH_FILE) || (ph == PH_DATA) ||
                     (ph == PH_EOF) || (ph == PH_BREAK);
    endfunction

endpackage

`default_nettype wire

>>> hdl/fsp_step.sv
`default_nettype none

module fsp_step (
    input  fsp_pkg::item_t       item,
    input  fsp_pkg::ctl_state_t  cur,
    input  logic [7:0]           max_tries,
    output fsp_pkg::ctl_state_t  nxt,
    output fsp_pkg::result_t     result
);

    fsp_pkg::ctl_state_t mid;
    logic                visit;
    logic                advance;
    logic [5:0]          seq_plus;

    assign seq_plus = cur.seq + 6'd1;

    // next state: reply handling, then the try check on the resulting phase
    always_comb
    begin
        mid     = cur;
        visit   = 1'b0;
        advance = 1'b0;
        if (item.cmd == fsp_pkg::CMD_START)
        begin
            mid.phase = fsp_pkg::PH_INIT;
            mid.seq   = '0;
            mid.tries = '0;
            visit     = 1'b1;
        end
        else if (fsp_pkg::is_sending(cur.phase))
        begin
            visit = 1'b1;
            if (item.cmd == fsp_pkg::CMD_REPLY)
            begin
                case (item.reply_type)
                    fsp_pkg::REPLY_ACK: advance = (item.reply_seq == cur.seq);
                    fsp_pkg::REPLY_NAK: advance = (item.reply_seq == seq_plus);
                    default:            mid.phase = fsp_pkg::PH_ABORT;
                endcase
            end
        end

        if (advance)
        begin
            mid.tries = '0;
            mid.seq   = seq_plus;
            case (cur.phase)
                fsp_pkg::PH_INIT:
                    mid.phase = item.file_ok ? fsp_pkg::PH_FILE : fsp_pkg::PH_ABORT;
                fsp_pkg::PH_FILE:
                    mid.phase = fsp_pkg::PH_DATA;
                fsp_pkg::PH_DATA:
                    mid.phase = item.data_eof ? fsp_pkg::PH_EOF : fsp_pkg::PH_DATA;
                fsp_pkg::PH_EOF:
                begin
                    // another file: back to init, keep the sequence
                    if (item.more_files)
                    begin
                        mid.phase = fsp_pkg::PH_INIT;
                        mid.seq   = cur.seq;
                    end
                    else
                    begin
                        mid.phase = fsp_pkg::PH_BREAK;
                    end
                end
                default:
                    mid.phase = fsp_pkg::PH_DONE;
            endcase
        end

        nxt = mid;
        if (visit && fsp_pkg::is_sending(mid.phase))
        begin
            if (mid.tries > max_tries)
                nxt.phase = fsp_pkg::PH_ABORT;
            else if (mid.tries != fsp_pkg::TRY_TOP)
                nxt.tries = mid.tries + 8'd1;
        end
    end

    // result from the phase after this beat
    always_comb
    begin
        result.send_type = fsp_pkg::SEND_NONE;
        result.send_seq  = '0;
        result.status    = fsp_pkg::STATUS_RUNNING;
        case (nxt.phase)
            fsp_pkg::PH_DONE:  result.status = fsp_pkg::STATUS_COMPLETE;
            fsp_pkg::PH_ABORT: result.status = fsp_pkg::STATUS_ABORTED;
            fsp_pkg::PH_IDLE:  result.status = fsp_pkg::STATUS_RUNNING;
            default:
            begin
                result.send_type = nxt.phase - 3'd1;
                result.send_seq  = nxt.seq;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/file_send_protocol_fsm.sv
// Sender control for a stop-and-wait file transfer link.
// Input stream (s_*): one beat per event. s_tuser carries the command
// (start, reply received, receive failure); s_tdata carries the reply
// fields and the file/data status flags.
// Output stream (m_*): exactly one beat per input beat, telling which
// packet to send next with its sequence number, plus the transfer status.
// Latency: the result for a beat appears on m_* the cycle after it is
// accepted. Throughput: one beat per cycle unless m_tready holds the
// output; phase, sequence and try count are updated by a single pass of
// next-state logic, and a one-entry output register holds the result.
// Stall: while a result waits on m_tready low, s_tready drops; a new beat
// is taken in the same cycle the waiting result leaves.
// Reset: phase idle, sequence 0, try count 0, max_tries 10, output empty.
// cfg_we writes max_tries from cfg_wdata; write it only while idle.
`default_nettype none

`include "file_send_protocol_fsm_defines.svh"

module file_send_protocol_fsm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,   // max_tries
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // reply_type[1:0], reply_seq[7:2], file_ok[8],
                                     // data_eof[9], more_files[10], zero fill
    input  logic [1:0]  s_tuser,     // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata      // send_type[2:0], send_seq[8:3], status[10:9],
                                     // zero fill
);

    logic [7:0]          max_tries_reg;
    fsp_pkg::ctl_state_t state_reg;
    fsp_pkg::ctl_state_t state_next;
    fsp_pkg::result_t    out_reg;
    fsp_pkg::result_t    out_next;
    logic                out_valid_reg;
    fsp_pkg::item_t      item;
    logic                accept;

    assign item.cmd        = s_tuser;
    assign item.reply_type = s_tdata[1:0];
    assign item.reply_seq  = s_tdata[7:2];
    assign item.file_ok    = s_tdata[8];
    assign item.data_eof   = s_tdata[9];
    assign item.more_files = s_tdata[10];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg};

    fsp_step u_step (
        .item      (item),
        .cur       (state_reg),
        .max_tries (max_tries_reg),
        .nxt       (state_next),
        .result    (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tries_reg   <= fsp_pkg::MAX_TRIES_RESET;
            state_reg.phase <= fsp_pkg::PH_IDLE;
            state_reg.seq   <= '0;
            state_reg.tries <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_tries_reg <= cfg_wdata;
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: load on every accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    `FSP_ASSERT(a_stopped_sends_nothing,
        (out_valid_reg && out_reg.status != fsp_pkg::STATUS_RUNNING) |->
        (out_reg.send_type == fsp_pkg::SEND_NONE && out_reg.send_seq == 6'd0))
    `FSP_ASSERT(a_idle_is_clean,
        (state_reg.phase == fsp_pkg::PH_IDLE) |->
        (state_reg.seq == 6'd0 && state_reg.tries == 8'd0))
    `FSP_ASSERT(a_start_enters_init,
        (accept && item.cmd == fsp_pkg::CMD_START) |=>
        (state_reg.phase == fsp_pkg::PH_INIT && state_reg.seq == 6'd0 &&
         state_reg.tries == 8'd1))
    `FSP_ASSERT(a_done_tries_clear,
        (state_reg.phase == fsp_pkg::PH_DONE) |-> (state_reg.tries == 8'd0))
    `FSP_ASSERT_ALWAYS(a_reset_output_empty,
        (!rst_n) |-> (!m_tvalid))

endmodule

`default_nettype wire
